>>> sv/htfd_pkg.sv
package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUMI_SPAN   = 14'd10000;

    localparam int QUEUE_DEPTH_DFLT = 4;

    localparam logic [2:0] POS_TEMP_HI = 3'd0;
    localparam logic [2:0] POS_TEMP_LO = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUMI_HI = 3'd3;
    localparam logic [2:0] POS_HUMI_LO = 3'd4;
    localparam logic [2:0] POS_HUMI_CRC = 3'd5;

    typedef struct packed {
        logic        temp_ok;
        logic        humi_ok;
        logic [15:0] temp_raw;
        logic [15:0] humi_raw;
    } t_frame;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/humidity_temp_frame_decode.sv
// Humidity and temperature sensor frame decoder.
// Input channel (i_in_valid / o_in_ready): one response byte per item, in the
// order temperature high, low, CRC, humidity high, low, CRC. i_frame_start
// marks the first byte of a frame and drops any partial frame.
// Output channel (o_out_valid / i_out_ready): one item per complete frame with
// both raw words, a CRC-8 pass flag per word, the overall status and the
// scaled values in hundredths.
// Throughput: one byte per cycle while the queue has room. The front end
// updates the CRC and word registers in the cycle a byte is taken and writes
// each finished frame into a small queue.
// After the sixth byte the frame goes into the queue, then through registered
// stages: multiply, quotient estimate, correction and output register.
// When the receiver stalls, the back-end pipeline holds; frames collect in the
// queue and o_in_ready falls only once the queue is full.
// Reset (synchronous, active low) empties the queue and pipeline and returns
// the front end to the first byte of a frame with the CRC at its initial value.
module humidity_temp_frame_decode #(
    parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic               o_temp_crc_ok,
    output logic               o_humi_crc_ok,
    output logic [15:0]        o_temp_raw,
    output logic [15:0]        o_humi_raw,
    output logic signed [14:0] o_temp_centi,
    output logic [13:0]        o_humi_centi
);
    import htfd_pkg::*;

    logic    w_accept, w_push, w_pop, w_full, w_empty;
    t_frame  w_wr_frame, w_rd_frame;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    htfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_push        (w_push),
        .o_frame       (w_wr_frame)
    );

    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_wr_frame),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_frame),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    htfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (w_rd_frame),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_status      (o_status),
        .o_temp_crc_ok (o_temp_crc_ok),
        .o_humi_crc_ok (o_humi_crc_ok),
        .o_temp_raw    (o_temp_raw),
        .o_humi_raw    (o_humi_raw),
        .o_temp_centi  (o_temp_centi),
        .o_humi_centi  (o_humi_centi)
    );

    a_status_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == !(o_temp_crc_ok && o_humi_crc_ok)))
        else $error("status disagrees with CRC flags");

    a_humi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_humi_centi <= 14'd10000))
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temp_centi >= -15'sd4500 && o_temp_centi <= 15'sd13000))
        else $error("temperature out of range");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("frame pushed into full queue");

endmodule

>>> sv/htfd_front.sv
module htfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_frame_start,
    output logic                o_push,
    output htfd_pkg::t_frame    o_frame
);
    import htfd_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp_word, n_temp_word;
    logic [15:0] r_humi_word, n_humi_word;
    logic        r_temp_ok, n_temp_ok;
    logic [2:0]  w_pos;
    logic        w_humi_ok;

    always_comb begin
        w_pos = (i_frame_start || r_pos > POS_HUMI_CRC) ? POS_TEMP_HI : r_pos;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_temp_word = r_temp_word;
        n_humi_word = r_humi_word;
        n_temp_ok   = r_temp_ok;
        w_humi_ok   = (r_crc == i_data_byte);
        o_push      = 1'b0;
        if (i_accept) begin
            n_pos = w_pos + 3'd1;
            unique case (w_pos)
                POS_TEMP_HI: begin
                    n_temp_word = {i_data_byte, 8'h00};
                    n_crc       = crc_byte(CRC_INIT, i_data_byte);
                end
                POS_TEMP_LO: begin
                    n_temp_word = {r_temp_word[15:8], i_data_byte};
                    n_crc       = crc_byte(r_crc, i_data_byte);
                end
                POS_TEMP_CRC: begin
                    n_temp_ok = (r_crc == i_data_byte);
                    n_crc     = CRC_INIT;
                end
                POS_HUMI_HI: begin
                    n_humi_word = {i_data_byte, 8'h00};
                    n_crc       = crc_byte(CRC_INIT, i_data_byte);
                end
                POS_HUMI_LO: begin
                    n_humi_word = {r_humi_word[15:8], i_data_byte};
                    n_crc       = crc_byte(r_crc, i_data_byte);
                end
                default: begin
                    n_pos  = POS_TEMP_HI;
                    n_crc  = CRC_INIT;
                    o_push = 1'b1;
                end
            endcase
        end
    end

    assign o_frame = '{temp_ok: r_temp_ok, humi_ok: w_humi_ok,
                       temp_raw: r_temp_word, humi_raw: r_humi_word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_TEMP_HI;
            r_crc       <= CRC_INIT;
            r_temp_word <= '0;
            r_humi_word <= '0;
            r_temp_ok   <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_word <= n_temp_word;
            r_humi_word <= n_humi_word;
            r_temp_ok   <= n_temp_ok;
        end
    end

endmodule

>>> sv/htfd_queue.sv
module htfd_queue #(
    parameter int DEPTH = htfd_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  htfd_pkg::t_frame    i_wr_data,
    input  logic                i_pop,
    output htfd_pkg::t_frame    o_rd_data,
    output logic                o_full,
    output logic                o_empty
);
    import htfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_frame          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push, w_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push    = i_push && !o_full;
    assign w_pop     = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> sv/htfd_back.sv
module htfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  htfd_pkg::t_frame    i_frame,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic                o_temp_crc_ok,
    output logic                o_humi_crc_ok,
    output logic [15:0]         o_temp_raw,
    output logic [15:0]         o_humi_raw,
    output logic signed [14:0]  o_temp_centi,
    output logic [13:0]         o_humi_centi
);
    import htfd_pkg::*;

    logic          w_adv;
    logic          r_s1_vld, r_s2_vld, r_out_vld;
    t_frame        r_s1_frm, r_s2_frm;
    logic [30:0]   r_s1_tp, r_s2_tp;
    logic [29:0]   r_s1_hp, r_s2_hp;
    logic [14:0]   r_s2_te;
    logic [13:0]   r_s2_he;
    logic [14:0]   w_te;
    logic [13:0]   w_he;
    logic [16:0]   w_t_rem, w_h_rem;
    logic [14:0]   w_tq;
    logic [13:0]   w_hq;
    logic          r_status, r_temp_ok, r_humi_ok;
    logic [15:0]   r_temp_raw, r_humi_raw;
    logic [14:0]   r_temp_centi;
    logic [13:0]   r_humi_centi;

    assign w_adv = !r_out_vld || i_ready;
    assign o_pop = w_adv && !i_empty;

    // estimate floor(p / 65535), low by at most one
    assign w_te = 15'((r_s1_tp + (r_s1_tp >> 16)) >> 16);
    assign w_he = 14'((r_s1_hp + (r_s1_hp >> 16)) >> 16);

    assign w_t_rem = 17'(r_s2_tp - (31'(r_s2_te) << 16) + 31'(r_s2_te));
    assign w_h_rem = 17'(r_s2_hp - (30'(r_s2_he) << 16) + 30'(r_s2_he));
    assign w_tq    = r_s2_te + 15'(w_t_rem >= FULL_SCALE);
    assign w_hq    = r_s2_he + 14'(w_h_rem >= FULL_SCALE);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_frm     <= i_frame;
            r_s1_tp      <= {15'b0, i_frame.temp_raw} * {16'b0, TEMP_SPAN};
            r_s1_hp      <= {14'b0, i_frame.humi_raw} * {16'b0, HUMI_SPAN};
            r_s2_frm     <= r_s1_frm;
            r_s2_tp      <= r_s1_tp;
            r_s2_hp      <= r_s1_hp;
            r_s2_te      <= w_te;
            r_s2_he      <= w_he;
            r_status     <= !(r_s2_frm.temp_ok && r_s2_frm.humi_ok);
            r_temp_ok    <= r_s2_frm.temp_ok;
            r_humi_ok    <= r_s2_frm.humi_ok;
            r_temp_raw   <= r_s2_frm.temp_raw;
            r_humi_raw   <= r_s2_frm.humi_raw;
            r_temp_centi <= w_tq - TEMP_OFFSET;
            r_humi_centi <= w_hq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= !i_empty;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_status;
    assign o_temp_crc_ok = r_temp_ok;
    assign o_humi_crc_ok = r_humi_ok;
    assign o_temp_raw    = r_temp_raw;
    assign o_humi_raw    = r_humi_raw;
    assign o_temp_centi  = $signed(r_temp_centi);
    assign o_humi_centi  = r_humi_centi;

endmodule

>>> tb/tb_top.sv
module tb_top;
    import htfd_pkg::*;

    typedef struct packed {
        logic               status;
        logic               temp_ok;
        logic               humi_ok;
        logic [15:0]        temp_raw;
        logic [15:0]        humi_raw;
        logic signed [14:0] temp_centi;
        logic [13:0]        humi_centi;
    } t_reading;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        t_reading   want;
    } t_byte_row;

    localparam t_reading NO_READING = '0;
    localparam int N_ROWS = 26;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_data_byte   = 8'h00;
    logic               i_frame_start = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic               o_status;
    logic               o_temp_crc_ok;
    logic               o_humi_crc_ok;
    logic [15:0]        o_temp_raw;
    logic [15:0]        o_humi_raw;
    logic signed [14:0] o_temp_centi;
    logic [13:0]        o_humi_centi;

    // decoder state mirrored by the checker
    logic [2:0]  pos_q   = POS_TEMP_HI;
    logic [7:0]  crc_q   = CRC_INIT;
    logic [15:0] tword_q = 16'h0000;
    logic [15:0] hword_q = 16'h0000;
    logic        tok_q   = 1'b0;

    t_reading    pending_readings[$];
    t_byte_row   frame_rows[N_ROWS];
    int          mismatches   = 0;
    int          bytes_sent   = 0;
    int          snd_idle_pct = 35;
    int          rcv_idle_pct = 48;

    humidity_temp_frame_decode u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_temp_crc_ok (o_temp_crc_ok),
        .o_humi_crc_ok (o_humi_crc_ok),
        .o_temp_raw    (o_temp_raw),
        .o_humi_raw    (o_humi_raw),
        .o_temp_centi  (o_temp_centi),
        .o_humi_centi  (o_humi_centi)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ d[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic s, output t_reading r);
        logic [2:0]  p;
        logic        hok;
        logic [31:0] t;
        logic [31:0] h;
        r = NO_READING;
        p = pos_q;
        decode_byte = 1'b0;
        if (s || p > POS_HUMI_CRC) begin
            p = POS_TEMP_HI;
        end
        case (p)
            POS_TEMP_HI: begin
                tword_q = {b, 8'h00};
                crc_q   = crc_step(CRC_INIT, b);
            end
            POS_TEMP_LO: begin
                tword_q = {tword_q[15:8], b};
                crc_q   = crc_step(crc_q, b);
            end
            POS_TEMP_CRC: begin
                tok_q = (crc_q == b);
                crc_q = CRC_INIT;
            end
            POS_HUMI_HI: begin
                hword_q = {b, 8'h00};
                crc_q   = crc_step(CRC_INIT, b);
            end
            POS_HUMI_LO: begin
                hword_q = {hword_q[15:8], b};
                crc_q   = crc_step(crc_q, b);
            end
            default: begin
                hok = (crc_q == b);
                t = (32'(tword_q) * 32'(TEMP_SPAN)) / 32'(FULL_SCALE);
                h = (32'(hword_q) * 32'(HUMI_SPAN)) / 32'(FULL_SCALE);
                r.status     = !(tok_q && hok);
                r.temp_ok    = tok_q;
                r.humi_ok    = hok;
                r.temp_raw   = tword_q;
                r.humi_raw   = hword_q;
                r.temp_centi = 15'(t - 32'(TEMP_OFFSET));
                r.humi_centi = 14'(h);
                crc_q = CRC_INIT;
                decode_byte = 1'b1;
            end
        endcase
        pos_q = decode_byte ? POS_TEMP_HI : p + 3'd1;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic s, input logic typed,
                            input t_reading want);
        t_reading r;
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (decode_byte(b, s, r)) begin
            pending_readings.push_back(typed ? want : r);
        end
        bytes_sent++;
    endtask

    function automatic logic [15:0] pick_word();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'hFFFF;
        return 16'($urandom_range(65535));
    endfunction

    function automatic logic [7:0] pick_crc(input logic [15:0] w);
        return ($urandom_range(99) < 80) ? word_crc(w) : 8'($urandom_range(255));
    endfunction

    task automatic random_traffic(input int n_bytes);
        int          stop_at;
        int          kind;
        int          n;
        logic [15:0] tw;
        logic [15:0] hw;
        logic        s;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                tw = pick_word();
                hw = pick_word();
                s  = (pos_q == POS_TEMP_HI) ? 1'($urandom_range(1)) : 1'b1;
                put_byte(tw[15:8], s, 1'b0, NO_READING);
                put_byte(tw[7:0], 1'b0, 1'b0, NO_READING);
                put_byte(pick_crc(tw), 1'b0, 1'b0, NO_READING);
                put_byte(hw[15:8], 1'b0, 1'b0, NO_READING);
                put_byte(hw[7:0], 1'b0, 1'b0, NO_READING);
                put_byte(pick_crc(hw), 1'b0, 1'b0, NO_READING);
            end else if (kind < 90) begin
                // abandon a frame part way through
                n = $urandom_range(5, 1);
                put_byte(8'($urandom_range(255)), 1'b1, 1'b0, NO_READING);
                for (int i = 1; i < n; i++) begin
                    put_byte(8'($urandom_range(255)), 1'b0, 1'b0, NO_READING);
                end
            end else begin
                put_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, NO_READING);
            end
        end
    endtask

    task automatic cmp_field(input string nm, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", nm, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reading w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $error("reading with none pending: temp_raw %0h humi_raw %0h",
                       o_temp_raw, o_humi_raw);
                mismatches++;
            end else begin
                w = pending_readings.pop_front();
                cmp_field("status", w.status, o_status);
                cmp_field("temp_crc_ok", w.temp_ok, o_temp_crc_ok);
                cmp_field("humi_crc_ok", w.humi_ok, o_humi_crc_ok);
                cmp_field("temp_raw", w.temp_raw, o_temp_raw);
                cmp_field("humi_raw", w.humi_raw, o_humi_raw);
                cmp_field("temp_centi", int'(w.temp_centi), int'(o_temp_centi));
                cmp_field("humi_centi", w.humi_centi, o_humi_centi);
            end
        end
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin
        frame_rows = '{
            '{8'h00, 1'b1, 1'b0, NO_READING},
            '{8'h00, 1'b0, 1'b0, NO_READING},
            '{8'h81, 1'b0, 1'b0, NO_READING},
            '{8'hFF, 1'b0, 1'b0, NO_READING},
            '{8'hFF, 1'b0, 1'b0, NO_READING},
            '{8'hAC, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 16'h0000, 16'hFFFF,
                                   -15'sd4500, 14'd10000}},
            '{8'hFF, 1'b0, 1'b0, NO_READING},
            '{8'hFF, 1'b0, 1'b0, NO_READING},
            '{8'hAC, 1'b0, 1'b0, NO_READING},
            '{8'h00, 1'b0, 1'b0, NO_READING},
            '{8'h00, 1'b0, 1'b0, NO_READING},
            '{8'h81, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 16'hFFFF, 16'h0000,
                                   15'sd13000, 14'd0}},
            '{8'hBE, 1'b1, 1'b0, NO_READING},
            '{8'hEF, 1'b0, 1'b0, NO_READING},
            '{8'h00, 1'b0, 1'b0, NO_READING},
            '{8'hBE, 1'b0, 1'b0, NO_READING},
            '{8'hEF, 1'b0, 1'b0, NO_READING},
            '{8'h92, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 16'hBEEF, 16'hBEEF,
                                   15'sd8552, 14'd7458}},
            '{8'h12, 1'b1, 1'b0, NO_READING},
            '{8'h34, 1'b0, 1'b0, NO_READING},
            '{8'hBE, 1'b1, 1'b0, NO_READING},
            '{8'hEF, 1'b0, 1'b0, NO_READING},
            '{8'h92, 1'b0, 1'b0, NO_READING},
            '{8'hBE, 1'b0, 1'b0, NO_READING},
            '{8'hEF, 1'b0, 1'b0, NO_READING},
            '{8'h93, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 16'hBEEF, 16'hBEEF,
                                   15'sd8552, 14'd7458}}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            put_byte(frame_rows[i].data, frame_rows[i].start, frame_rows[i].typed,
                     frame_rows[i].want);
        end
        random_traffic(410);

        snd_idle_pct = 48;
        rcv_idle_pct = 35;
        random_traffic(410);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_traffic(410);
        i_in_valid <= 1'b0;

        // drain, then allow for the output pipeline
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
